[hdl/ksu_pkg.sv]
// shared types and constants for the k-subset unranking block
`timescale 1ns / 1ps

package ksu_pkg;

    localparam int RANK_W    = 64;
    localparam int MASK_W    = 64;
    localparam int BIN_W     = 64;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] SET_SIZE_RESET    = 7'd43;
    localparam logic [CFG_W-1:0] SUBSET_SIZE_RESET = 7'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_SIZE    = 1'b0,
        CFG_SUBSET_SIZE = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic fill;
        logic load;
        logic total;
        logic check;
        logic scan;
        logic out_load;
    } ksu_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic saturated;
        logic k_zero;
        logic scan_last;
    } ksu_status_t;

endpackage

[hdl/k_subset_unrank.sv]
// top level of the colex k-subset unranking block
//
//  channel   dir   tdata                  tuser
//  s_        in    [63:0] rank            -
//  m_        out   [63:0] subset_mask     [0] rank_saturated
//  cfg_      in    index 0 set_size, index 1 subset_size, 7-bit data
//
// after reset a table fill runs with s_tready low; configuration writes are
// taken during it
// after a beat is accepted the scan covers positions from n-1 down to the lowest
// chosen one, at most n, and is skipped when the rank saturates or k is zero;
// the scan visits one position per cycle, set by the two read ports of the
// binomial table
// one beat is in work at a time; a new beat is taken while the last result waits
`timescale 1ns / 1ps

module k_subset_unrank #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ksu_pkg::RANK_W-1:0]    s_tdata,   // [63:0] rank
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ksu_pkg::MASK_W-1:0]    m_tdata,   // [63:0] subset_mask
    output logic [0:0]                    m_tuser,   // [0] rank_saturated
    input  logic                          cfg_wr_en,
    input  logic [ksu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ksu_pkg::CFG_W-1:0]     cfg_wdata
);
    import ksu_pkg::*;

    ksu_cmd_t    cmd;
    ksu_status_t status;
    logic        rank_saturated;

    ksu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ksu_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .rank           (s_tdata),
        .cmd            (cmd),
        .status         (status),
        .subset_mask    (m_tdata),
        .rank_saturated (rank_saturated)
    );

    assign m_tuser = rank_saturated;

endmodule

[hdl/ksu_datapath.sv]
// binomial table, rank remainder, position scan and result register
`timescale 1ns / 1ps

module ksu_datapath #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ksu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ksu_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic [ksu_pkg::RANK_W-1:0]     rank,
    input  ksu_pkg::ksu_cmd_t              cmd,
    output ksu_pkg::ksu_status_t           status,
    output logic [ksu_pkg::MASK_W-1:0]     subset_mask,
    output logic                           rank_saturated
);
    import ksu_pkg::*;

    localparam int DIM   = MAX_ELEMENTS + 1;
    localparam int DEPTH = DIM * DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(DIM);

    function automatic logic [AW-1:0] tab_addr(input logic [IW-1:0] a, input logic [IW-1:0] b);
        return AW'(a) * AW'(DIM) + AW'(b);
    endfunction

    // pascal triangle, C(a,b) at a*DIM+b
    logic [BIN_W-1:0] mem [DEPTH];

    logic [CFG_W-1:0]  set_size_reg, subset_size_reg;
    logic [IW-1:0]     fill_a_reg, fill_b_reg;
    logic              fill_wr_reg;
    logic [IW-1:0]     fill_wa_reg, fill_wb_reg;
    logic [BIN_W-1:0]  prev_reg;
    logic [BIN_W-1:0]  rd_a_reg, rd_b_reg;
    logic [RANK_W-1:0] rem_reg;
    logic [IW-1:0]     n_reg, k_reg, p_reg, r_reg;
    logic              took_reg, sat_reg;
    logic [MASK_W-1:0] mask_reg, out_mask_reg;
    logic              out_sat_reg;

    logic [IW-1:0]     n_eff, k_eff, n_m1, k_m1, p_m1, r_m1, fill_a_m1;
    logic [AW-1:0]     addr_a, addr_b, waddr;
    logic [BIN_W-1:0]  wdata, cur;
    logic              hit, sat;
    logic [MASK_W-1:0] topk, pbit;

    assign n_eff = (set_size_reg > CFG_W'(MAX_ELEMENTS)) ? IW'(MAX_ELEMENTS)
                                                         : IW'(set_size_reg);
    assign k_eff = (subset_size_reg > CFG_W'(n_eff)) ? n_eff : IW'(subset_size_reg);

    assign n_m1      = (n_reg == '0) ? '0 : n_reg - 1'b1;
    assign k_m1      = (k_reg == '0) ? '0 : k_reg - 1'b1;
    assign p_m1      = (p_reg == '0) ? '0 : p_reg - 1'b1;
    assign r_m1      = (r_reg == '0) ? '0 : r_reg - 1'b1;
    assign fill_a_m1 = (fill_a_reg == '0) ? '0 : fill_a_reg - 1'b1;

    always_comb begin
        addr_a = tab_addr(p_m1, r_reg);
        addr_b = tab_addr(p_m1, r_m1);
        if (cmd.fill) begin
            addr_a = tab_addr(fill_a_m1, fill_b_reg);
            addr_b = '0;
        end else if (cmd.total) begin
            addr_a = tab_addr(n_reg, k_reg);
            addr_b = '0;
        end else if (cmd.check) begin
            addr_a = tab_addr(n_m1, k_reg);
            addr_b = tab_addr(n_m1, k_m1);
        end
    end

    assign waddr = tab_addr(fill_wa_reg, fill_wb_reg);
    assign wdata = (fill_wb_reg == '0) ? BIN_W'(1)
                 : (fill_wa_reg == '0) ? '0
                 : rd_a_reg + prev_reg;

    assign sat  = rem_reg >= rd_a_reg;
    assign topk = (~({MASK_W{1'b1}} << k_reg)) << (n_reg - k_reg);
    assign cur  = took_reg ? rd_b_reg : rd_a_reg;
    assign hit  = cur <= rem_reg;
    assign pbit = {{(MASK_W-1){1'b0}}, 1'b1} << p_reg;

    assign status.fill_last = (fill_a_reg == IW'(MAX_ELEMENTS)) &&
                              (fill_b_reg == IW'(MAX_ELEMENTS));
    assign status.saturated = sat;
    assign status.k_zero    = (k_reg == '0);
    assign status.scan_last = hit && (r_reg == IW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_size_reg    <= SET_SIZE_RESET;
            subset_size_reg <= SUBSET_SIZE_RESET;
            fill_a_reg      <= '0;
            fill_b_reg      <= '0;
            fill_wr_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SET_SIZE:    set_size_reg    <= cfg_wdata;
                    CFG_SUBSET_SIZE: subset_size_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            fill_wr_reg <= cmd.fill;
            if (cmd.fill) begin
                if (fill_b_reg == IW'(MAX_ELEMENTS)) begin
                    fill_b_reg <= '0;
                    fill_a_reg <= fill_a_reg + 1'b1;
                end else begin
                    fill_b_reg <= fill_b_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fill_wr_reg) begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    always_ff @(posedge aclk) begin
        fill_wa_reg <= fill_a_reg;
        fill_wb_reg <= fill_b_reg;
        if (fill_wr_reg) begin
            prev_reg <= rd_a_reg;
        end
        if (cmd.load) begin
            rem_reg <= rank;
            n_reg   <= n_eff;
            k_reg   <= k_eff;
        end
        if (cmd.check) begin
            p_reg    <= n_m1;
            r_reg    <= k_reg;
            took_reg <= 1'b0;
            sat_reg  <= sat;
            mask_reg <= sat ? topk : '0;
        end
        if (cmd.scan) begin
            p_reg    <= p_m1;
            took_reg <= hit;
            if (hit) begin
                rem_reg  <= rem_reg - cur;
                mask_reg <= mask_reg | pbit;
                r_reg    <= r_m1;
            end
        end
        if (cmd.out_load) begin
            out_mask_reg <= mask_reg;
            out_sat_reg  <= sat_reg;
        end
    end

    assign subset_mask    = out_mask_reg;
    assign rank_saturated = out_sat_reg;

endmodule

[hdl/ksu_ctrl.sv]
// sequencing state machine for table fill, range check and position scan
`timescale 1ns / 1ps

module ksu_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  ksu_pkg::ksu_status_t  status,
    output ksu_pkg::ksu_cmd_t     cmd
);
    import ksu_pkg::*;

    typedef enum logic [6:0] {
        ST_FILL  = 7'b0000001,
        ST_DRAIN = 7'b0000010,
        ST_IDLE  = 7'b0000100,
        ST_TOTAL = 7'b0001000,
        ST_CHECK = 7'b0010000,
        ST_SCAN  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_FILL: begin
                cmd.fill = 1'b1;
                if (status.fill_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_TOTAL;
                end
            end
            ST_TOTAL: begin
                cmd.total  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
                if (status.saturated || status.k_zero) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_FILL;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

[hdl/ksu_check.sv]
// port-level checker for the k-subset unranking block and its bind
`timescale 1ns / 1ps

module ksu_check (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [ksu_pkg::MASK_W-1:0] m_tdata,
    input logic [0:0]                 m_tuser
);
    import ksu_pkg::*;

    // table fill follows every reset
    a_fill_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    // one beat in work at a time
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready while a beat is in work");

    // a new result frees the input side at once
    a_result_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result shown while input still busy");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

endmodule

bind k_subset_unrank ksu_check u_check (.*);

[sim/ksu_unrank_checker.sv]
// colex k-subset unranking predictor and result scoreboard
`timescale 1ns / 1ps

module ksu_unrank_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [ksu_pkg::RANK_W-1:0]    s_tdata,   // [63:0] rank
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [ksu_pkg::MASK_W-1:0]    m_tdata,   // [63:0] subset_mask
    input  logic [0:0]                    m_tuser,   // [0] rank_saturated
    input  logic                          cfg_wr_en,
    input  logic [ksu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ksu_pkg::CFG_W-1:0]     cfg_wdata,
    output int                            fail_count,
    output int                            pending_beats,
    output int                            checked_beats,
    output int                            clamped_beats,
    output logic [ksu_pkg::BIN_W-1:0]     subset_count
);
    import ksu_pkg::*;

    localparam int MAX_N = 64;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              sat;
    } subset_beat_t;

    logic [BIN_W-1:0] choose_tab [0:MAX_N][0:MAX_N];
    logic [CFG_W-1:0] set_size_q;
    logic [CFG_W-1:0] subset_size_q;
    subset_beat_t     expected_subsets [$];

    initial begin
        for (int a = 0; a <= MAX_N; a++) begin
            for (int b = 0; b <= MAX_N; b++) begin
                if (b == 0)
                    choose_tab[a][b] = 64'd1;
                else if (a == 0)
                    choose_tab[a][b] = 64'd0;
                else
                    choose_tab[a][b] = choose_tab[a-1][b-1] + choose_tab[a-1][b];
            end
        end
        fail_count    = 0;
        pending_beats = 0;
        checked_beats = 0;
        clamped_beats = 0;
        subset_count  = 64'd1;
    end

    function automatic logic [BIN_W-1:0] binom(input int a, input int b);
        if (a < 0 || b < 0 || a > MAX_N || b > MAX_N)
            return '0;
        return choose_tab[a][b];
    endfunction

    function automatic void clamp_sizes(input logic [CFG_W-1:0] n_reg,
                                        input logic [CFG_W-1:0] k_reg,
                                        output int n, output int k);
        n = (n_reg > MAX_N) ? MAX_N : int'(n_reg);
        k = (k_reg > n) ? n : int'(k_reg);
    endfunction

    function automatic subset_beat_t unrank_colex(input logic [RANK_W-1:0] rank,
                                                  input logic [CFG_W-1:0] n_reg,
                                                  input logic [CFG_W-1:0] k_reg);
        subset_beat_t      res;
        logic [RANK_W-1:0] rem;
        logic [MASK_W-1:0] ones;
        int                n, k, cap, p;
        clamp_sizes(n_reg, k_reg, n, k);
        res.mask = '0;
        res.sat  = 1'b0;
        if (rank >= binom(n, k)) begin
            // clamp to the top-k elements
            res.sat = 1'b1;
            if (k > 0) begin
                ones     = (k >= MASK_W) ? '1 : ((64'd1 << k) - 64'd1);
                res.mask = ones << (n - k);
            end
        end else begin
            rem = rank;
            for (int r = k; r >= 1; r--) begin
                cap = n - 1 - (k - r);
                p   = r - 1;
                while (p < cap && binom(p + 1, r) <= rem)
                    p++;
                rem         = rem - binom(p, r);
                res.mask[p] = 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        subset_beat_t want;
        int           n_eff, k_eff;
        if (!aresetn) begin
            set_size_q    = SET_SIZE_RESET;
            subset_size_q = SUBSET_SIZE_RESET;
            expected_subsets.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_subsets.size() == 0) begin
                    $error("result beat with no rank waiting: subset_mask %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_subsets.pop_front();
                    if (m_tdata !== want.mask) begin
                        $error("subset_mask expected %h actual %h", want.mask, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.sat) begin
                        $error("rank_saturated expected %b actual %b", want.sat, m_tuser[0]);
                        fail_count++;
                    end
                    checked_beats++;
                    if (want.sat)
                        clamped_beats++;
                end
            end
            if (s_tvalid && s_tready)
                expected_subsets.push_back(unrank_colex(s_tdata, set_size_q, subset_size_q));
            if (cfg_wr_en) begin
                if (cfg_idx_t'(cfg_index) == CFG_SET_SIZE)
                    set_size_q = cfg_wdata;
                else
                    subset_size_q = cfg_wdata;
            end
        end
        pending_beats = expected_subsets.size();
        clamp_sizes(set_size_q, subset_size_q, n_eff, k_eff);
        subset_count = binom(n_eff, k_eff);
    end

endmodule

[sim/tb_k_subset_unrank.sv]
// stimulus and verdict for the k-subset unranking block
`timescale 1ns / 1ps

module tb_k_subset_unrank;
    import ksu_pkg::*;

    localparam int IDLE_LIMIT      = 20000;
    localparam int RANDOM_PHASES   = 10;
    localparam int BEATS_PER_PHASE = 110;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [RANK_W-1:0]    s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [MASK_W-1:0]    m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int                   fail_count, pending_beats, checked_beats, clamped_beats;
    logic [BIN_W-1:0]     subset_count;

    bit                   gaps_on;
    int                   rx_stall;
    int                   settings_run;

    always #2 aclk = ~aclk;

    k_subset_unrank i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ksu_unrank_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_beats (pending_beats),
        .checked_beats (checked_beats),
        .clamped_beats (clamped_beats),
        .subset_count  (subset_count)
    );

    // result-side stalls in bursts of random length
    always @(negedge aclk) begin
        if (rx_stall > 0)
            rx_stall--;
        else if (gaps_on && $urandom_range(0, 4) == 0)
            rx_stall = $urandom_range(1, 4);
        m_tready <= (rx_stall == 0);
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL k_subset_unrank");
        $finish;
    end

    task automatic write_sizes(input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] k);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SET_SIZE;
        cfg_wdata <= n;
        @(negedge aclk);
        cfg_index <= CFG_SUBSET_SIZE;
        cfg_wdata <= k;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        settings_run++;
    endtask

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_rank(input logic [RANK_W-1:0] rank, input bit gaps);
        if (gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rank;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_beats != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    function automatic logic [RANK_W-1:0] pick_rank(input logic [BIN_W-1:0] total);
        logic [RANK_W-1:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: begin
                return total - 64'd1;
            end
            1: begin
                return total;
            end
            2: begin
                return wide;
            end
            3: begin
                return '0;
            end
            default: begin
                return wide % total;
            end
        endcase
    endfunction

    initial begin
        logic [CFG_W-1:0] dir_n [8];
        logic [CFG_W-1:0] dir_k [8];
        logic [CFG_W-1:0] n, k;
        int               n_cap;
        bit               gaps;

        // reset, n at the maximum, k = n, k above n, n above the maximum, n zero and k zero
        dir_n = '{7'd43, 7'd64, 7'd127, 7'd64, 7'd1, 7'd0, 7'd10, 7'd5};
        dir_k = '{7'd5, 7'd32, 7'd64, 7'd1, 7'd1, 7'd5, 7'd0, 7'd9};
        gaps_on = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int d = 0; d < 8; d++) begin
            write_sizes(dir_n[d], dir_k[d]);
            send_rank(subset_count - 64'd1, 1'b0);
            send_rank(subset_count, 1'b0);
            send_rank((d % 2) ? '1 : '0, 1'b0);
            drain_results();
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 7))
                0: begin
                    n = CFG_W'($urandom_range(65, 127));
                end
                1: begin
                    n = 7'd64;
                end
                2: begin
                    n = CFG_W'($urandom_range(0, 3));
                end
                default: begin
                    n = CFG_W'($urandom_range(1, 63));
                end
            endcase
            n_cap = (n > 64) ? 64 : int'(n);
            case ($urandom_range(0, 5))
                0: begin
                    k = CFG_W'($urandom_range(0, 127));
                end
                1: begin
                    k = n;
                end
                default: begin
                    k = CFG_W'($urandom_range(0, n_cap));
                end
            endcase
            // one steady phase mid-run and one at the end
            gaps    = (ph != 4) && (ph != RANDOM_PHASES - 1);
            gaps_on = gaps;
            write_sizes(n, k);
            for (int i = 0; i < BEATS_PER_PHASE; i++) begin
                send_rank(pick_rank(subset_count), gaps);
                if (ph == 1 && i == BEATS_PER_PHASE / 2)
                    drain_results();
            end
            drain_results();
        end

        gaps_on = 1'b0;
        repeat (80) @(negedge aclk);
        $display("checked %0d subset beats over %0d size settings, %0d clamped to the top subset",
                 checked_beats, settings_run, clamped_beats);
        if (fail_count == 0)
            $display("PASS k_subset_unrank");
        else
            $display("FAIL k_subset_unrank");
        $finish;
    end

endmodule
